// ===== rtl/bns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bns_pkg
// Types and constants shared by the bitmap negative stream block.
// ----------------------------------------------------------------------------
package bns_pkg;

    // status code reported with every output byte
    typedef enum logic [3:0] {
        ST_PENDING     = 4'd0,
        ST_VALID       = 4'd1,
        ST_SIGNATURE   = 4'd2,
        ST_TRUNCATED   = 4'd3,
        ST_SIZE        = 4'd4,
        ST_RESERVED    = 4'd5,
        ST_DIB         = 4'd6,
        ST_PLANES      = 4'd7,
        ST_DEPTH       = 4'd8,
        ST_COMPRESSION = 4'd9,
        ST_COLOURS     = 4'd10,
        ST_PIXEL_SIZE  = 4'd11,
        ST_PALETTE     = 4'd12
    } t_status;

    localparam logic [15:0] SIG_VALUE   = 16'h4d42;
    localparam logic [31:0] HDR_BYTES   = 32'd54;
    localparam logic [31:0] HDR_LAST    = 32'd53;
    localparam logic [31:0] SIG_BYTES   = 32'd2;
    localparam logic [31:0] DIB_SIZE    = 32'd40;
    localparam logic [31:0] MAX_COLOURS = 32'd256;
    localparam logic [15:0] PLANES_ONE  = 16'd1;
    localparam logic [15:0] DEPTH_8     = 16'd8;
    localparam logic [15:0] DEPTH_24    = 16'd24;

    // header words that the checks and the pixel logic look at
    localparam int unsigned HDR_USED_WORDS = 12;
    localparam int unsigned WORD_SEL_W     = 4;

    localparam logic [WORD_SEL_W-1:0] W_FILE_SIZE = 4'd0;
    localparam logic [WORD_SEL_W-1:0] W_RESERVED  = 4'd1;
    localparam logic [WORD_SEL_W-1:0] W_OFFSET    = 4'd2;
    localparam logic [WORD_SEL_W-1:0] W_DIB_SIZE  = 4'd3;
    localparam logic [WORD_SEL_W-1:0] W_WIDTH     = 4'd4;
    localparam logic [WORD_SEL_W-1:0] W_HEIGHT    = 4'd5;
    localparam logic [WORD_SEL_W-1:0] W_FORMAT    = 4'd6;
    localparam logic [WORD_SEL_W-1:0] W_COMPRESS  = 4'd7;
    localparam logic [WORD_SEL_W-1:0] W_COLOURS   = 4'd11;

    // byte positions at which the pixel-area product is prepared;
    // width, height and format words are all complete by then
    localparam logic [31:0] IDX_ROW_SETUP = 32'd30;
    localparam logic [31:0] IDX_AREA_MUL  = 32'd31;

endpackage

// ===== rtl/bns_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bns_in_if
// Input byte channel: one file byte and its last-byte flag per transaction.
// ----------------------------------------------------------------------------
interface bns_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       final_byte;

    modport source (output valid, output byte_in, output final_byte, input ready);
    modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

// ===== rtl/bns_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bns_out_if
// Output byte channel: echoed byte, header status and end flag.
// ----------------------------------------------------------------------------
interface bns_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [3:0] status;
    logic       end_marker;

    modport source (output valid, output byte_out, output status, output end_marker,
                    input ready);
    modport sink   (input valid, input byte_out, input status, input end_marker,
                    output ready);
endinterface

// ===== rtl/bns_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bns_cfg_if
// Configuration write channel carrying the expected file length.
// ----------------------------------------------------------------------------
interface bns_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] stream_length;

    modport source (output valid, output stream_length, input ready);
    modport sink   (input valid, input stream_length, output ready);
endinterface

// ===== rtl/bmp_negative_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_negative_stream
// Streams a bitmap file byte by byte, checks its 54-byte header and inverts
// palette colours (8-bit files) or pixel colour bytes (24-bit files).
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : file bytes, final_byte set on the last byte of each file.
//   o_out  : one transaction per input byte: the byte (possibly inverted), the
//            header status after that byte, and a copy of final_byte.
//   i_cfg  : expected file length; write it between files, always ready.
// Throughput is one byte per clock while o_out is not stalled. An accepted
// byte sits in the input stage, is processed against the stream state and
// lands in the output register when the input stage advances. The output
// register and the input stage form a two-entry pipe: a new byte is taken
// while a result waits, and i_in.ready only drops when both are full and
// o_out.ready is low. The header decision at the last header byte compares
// a padded-row-length-times-rows product that is formed by one 32x32
// multiply at byte 31, ahead of the last header byte.
// Reset empties the pipe, clears the length register and starts a new file;
// a byte with final_byte set also restarts the file state.
// ----------------------------------------------------------------------------
module bmp_negative_stream (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bns_in_if.sink     i_in,
    bns_out_if.source  o_out,
    bns_cfg_if.sink    i_cfg
);
    import bns_pkg::*;

    // configuration
    logic [31:0] r_stream_length;

    // input stage
    logic        r_s1_v;
    logic [7:0]  r_s1_byte;
    logic        r_s1_fin;

    // output register
    logic        r_o_v,      n_o_v;
    logic [7:0]  r_o_byte;
    t_status     r_o_status;
    logic        r_o_end;

    // stream state
    logic [31:0] r_idx,      n_idx;
    logic [31:0] r_hdr [HDR_USED_WORDS];
    logic [7:0]  r_sig_lo;
    logic [33:0] r_row_cnt,  n_row_cnt;
    logic [1:0]  r_pad,      n_pad;
    t_status     r_status,   n_status;

    // pixel-area precompute
    logic [33:0] r_row_len;
    logic [33:0] r_row_pix;
    logic [31:0] r_rows;
    logic [31:0] r_area_lo;
    logic        r_area_ovf;

    logic        s1_adv;
    logic [7:0]  res_byte;
    t_status     res_status;
    t_status     judge;
    logic        hdr_wr;
    logic [5:0]  hdr_k;
    logic [WORD_SEL_W-1:0] hdr_sel;

    logic [31:0] w_width, w_height, w_offset, w_colours;
    logic [15:0] w_depth;
    logic [63:0] area_prod;
    logic        area_ok;
    logic [31:0] pal_pos;
    logic [33:0] cnt_inc;

    assign w_width   = r_hdr[W_WIDTH];
    assign w_height  = r_hdr[W_HEIGHT];
    assign w_offset  = r_hdr[W_OFFSET];
    assign w_colours = r_hdr[W_COLOURS];
    assign w_depth   = r_hdr[W_FORMAT][31:16];

    // handshakes
    assign s1_adv     = r_s1_v && (!r_o_v || o_out.ready);
    assign i_in.ready = !r_s1_v || s1_adv;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_o_v;
    assign o_out.byte_out   = r_o_byte;
    assign o_out.status     = r_o_status;
    assign o_out.end_marker = r_o_end;

    assign area_prod = r_row_len[31:0] * r_rows;
    assign hdr_k     = r_idx[5:0] - SIG_BYTES[5:0];
    assign hdr_sel   = hdr_k[5:2];
    assign pal_pos   = r_idx - HDR_BYTES;
    assign cnt_inc   = r_row_cnt + 34'd1;

    // pixel bytes must exactly fill the file from the offset on
    assign area_ok = (w_offset <= r_stream_length) && !r_area_ovf &&
                     (r_area_lo == r_stream_length - w_offset);

    // header checks, first failure wins
    always_comb begin
        priority if (r_hdr[W_FILE_SIZE] != r_stream_length) begin
            judge = ST_SIZE;
        end else if (r_hdr[W_RESERVED] != 32'd0) begin
            judge = ST_RESERVED;
        end else if (r_hdr[W_DIB_SIZE] != DIB_SIZE) begin
            judge = ST_DIB;
        end else if (r_hdr[W_FORMAT][15:0] != PLANES_ONE) begin
            judge = ST_PLANES;
        end else if (w_depth != DEPTH_8 && w_depth != DEPTH_24) begin
            judge = ST_DEPTH;
        end else if (r_hdr[W_COMPRESS] != 32'd0) begin
            judge = ST_COMPRESSION;
        end else if (w_depth == DEPTH_8 && w_colours > MAX_COLOURS) begin
            judge = ST_COLOURS;
        end else if (!area_ok) begin
            judge = ST_PIXEL_SIZE;
        end else if (w_depth == DEPTH_8 && (w_offset < HDR_BYTES ||
                     {w_colours[29:0], 2'b00} != w_offset - HDR_BYTES)) begin
            judge = ST_PALETTE;
        end else begin
            judge = ST_VALID;
        end
    end

    // per-byte processing in the input stage
    always_comb begin
        n_status  = r_status;
        n_row_cnt = r_row_cnt;
        n_pad     = r_pad;
        res_byte  = r_s1_byte;
        hdr_wr    = 1'b0;

        if (r_status == ST_PENDING) begin
            if (r_idx < SIG_BYTES) begin
                if (r_idx[0] && {r_s1_byte, r_sig_lo} != SIG_VALUE) begin
                    n_status = ST_SIGNATURE;
                end
            end else if (r_idx < HDR_BYTES) begin
                hdr_wr = (hdr_sel < WORD_SEL_W'(HDR_USED_WORDS));
                if (r_idx == HDR_LAST) begin
                    n_status = judge;
                end
            end
            if (n_status == ST_PENDING && r_s1_fin) begin
                n_status = ST_TRUNCATED;
            end
        end else if (r_status == ST_VALID && r_idx >= HDR_BYTES &&
                     r_idx < r_hdr[W_FILE_SIZE]) begin
            if (w_depth == DEPTH_8) begin
                // palette entries are b, g, r, reserved
                if ({2'b00, pal_pos} < {w_colours, 2'b00} && pal_pos[1:0] != 2'd3) begin
                    res_byte = ~r_s1_byte;
                end
            end else if (r_idx >= w_offset && w_width != 32'd0) begin
                if (r_pad != 2'd0) begin
                    n_pad = r_pad - 2'd1;
                end else begin
                    res_byte = ~r_s1_byte;
                    if (cnt_inc >= r_row_pix) begin
                        n_row_cnt = 34'd0;
                        n_pad     = w_width[1:0];
                    end else begin
                        n_row_cnt = cnt_inc;
                    end
                end
            end
        end

        // the last byte reports its status before the file state restarts
        res_status = n_status;

        n_idx = (r_idx != '1) ? r_idx + 32'd1 : r_idx;
        if (r_s1_fin) begin
            n_idx     = 32'd0;
            n_row_cnt = 34'd0;
            n_pad     = 2'd0;
            n_status  = ST_PENDING;
        end
    end

    always_comb begin
        n_o_v = r_o_v;
        if (s1_adv) begin
            n_o_v = 1'b1;
        end else if (o_out.ready) begin
            n_o_v = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= 32'd0;
            r_s1_v          <= 1'b0;
            r_o_v           <= 1'b0;
            r_idx           <= 32'd0;
            r_row_cnt       <= 34'd0;
            r_pad           <= 2'd0;
            r_status        <= ST_PENDING;
        end else begin
            if (i_cfg.valid) begin
                r_stream_length <= i_cfg.stream_length;
            end
            if (i_in.valid && i_in.ready) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            r_o_v <= n_o_v;
            if (s1_adv) begin
                r_idx     <= n_idx;
                r_row_cnt <= n_row_cnt;
                r_pad     <= n_pad;
                r_status  <= n_status;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte <= i_in.byte_in;
            r_s1_fin  <= i_in.final_byte;
        end
        if (s1_adv) begin
            r_o_byte   <= res_byte;
            r_o_status <= res_status;
            r_o_end    <= r_s1_fin;
            if (r_status == ST_PENDING && r_idx == 32'd0) begin
                r_sig_lo <= r_s1_byte;
            end
            if (hdr_wr) begin
                unique case (hdr_k[1:0])
                    2'd0: r_hdr[hdr_sel][7:0]   <= r_s1_byte;
                    2'd1: r_hdr[hdr_sel][15:8]  <= r_s1_byte;
                    2'd2: r_hdr[hdr_sel][23:16] <= r_s1_byte;
                    default: r_hdr[hdr_sel][31:24] <= r_s1_byte;
                endcase
            end
            if (r_idx == IDX_ROW_SETUP) begin
                r_row_pix <= {2'b00, w_width} + {1'b0, w_width, 1'b0};
                if (w_depth == DEPTH_24) begin
                    r_row_len <= {2'b00, w_width} + {1'b0, w_width, 1'b0} +
                                 {32'd0, w_width[1:0]};
                end else begin
                    r_row_len <= {2'b00, w_width} + {32'd0, 2'd0 - w_width[1:0]};
                end
                r_rows <= w_height[31] ? 32'd0 - w_height : w_height;
            end
            if (r_idx == IDX_AREA_MUL) begin
                r_area_lo  <= area_prod[31:0];
                r_area_ovf <= (|area_prod[63:32]) ||
                              ((|r_row_len[33:32]) && r_rows != 32'd0);
            end
        end
    end

    // a processed last byte always restarts the file state
    a_fin_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_fin |=> r_idx == 32'd0 && r_status == ST_PENDING)
        else $error("file state not cleared after last byte");

    // the last byte of a file never leaves with a pending status
    a_end_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_end |-> r_o_status != ST_PENDING)
        else $error("end of file reported with pending status");

    // row padding only exists inside a valid 24-bit file
    a_pad_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad != 2'd0 |-> r_status == ST_VALID && w_depth == DEPTH_24)
        else $error("padding count outside a valid 24-bit file");

    // a decided status holds until the file ends
    a_status_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_status != ST_PENDING && !r_s1_fin |=> r_status == $past(r_status))
        else $error("decided status changed inside a file");

    // a full pipe with a stalled receiver takes no new byte
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_o_v && !o_out.ready |-> !i_in.ready)
        else $error("input accepted while pipe full and stalled");

endmodule
